// ===== hdl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared widths, register map, reset values and event codes of the button
// press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CFG_BITS   = 16;
    localparam int ADDR_BITS  = 4;
    localparam int DATA_BITS  = 32;

    typedef logic [TIMER_BITS-1:0] timer_t;
    typedef logic [CFG_BITS-1:0]   cfg_t;
    typedef logic [1:0]            event_kind_t;

    localparam event_kind_t EV_SINGLE = 2'd0;
    localparam event_kind_t EV_DOUBLE = 2'd1;
    localparam event_kind_t EV_LONG   = 2'd2;
    localparam event_kind_t EV_UNUSED = 2'd3;

    localparam logic [ADDR_BITS-1:0] ADDR_DEBOUNCE   = 4'h0;
    localparam logic [ADDR_BITS-1:0] ADDR_DOUBLE_GAP = 4'h4;
    localparam logic [ADDR_BITS-1:0] ADDR_LONG_PRESS = 4'h8;

    localparam cfg_t DEBOUNCE_RESET   = 16'd50;
    localparam cfg_t DOUBLE_GAP_RESET = 16'd400;
    localparam cfg_t LONG_PRESS_RESET = 16'd2000;

    function automatic timer_t sat_inc(input timer_t v);
        timer_t r;
        if (v == {TIMER_BITS{1'b1}})
        begin
            r = v;
        end
        else
        begin
            r = v + timer_t'(1);
        end
        return r;
    endfunction

endpackage

// ===== hdl/button_press_classifier.sv =====
// ----------------------------------------------------------------------------
// button_press_classifier
// Classifies active-low button presses sampled once per tick into single,
// double and long press events, with an APB register port for the timings.
// ----------------------------------------------------------------------------
// output: a result item is registered and shown on m_tvalid in the cycle after
// the input item that causes it is accepted
// throughput: one input item per cycle; s_tready drops only while a result
// item waits in the output register and m_tready is low
// reset: rst_n clears all press state and the output valid flag and loads the
// register defaults (debounce 50, double gap 400, long press 2000)
module button_press_classifier
    import bpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [0] button_level, [7:1] zero
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [1:0] event_kind, [7:2] zero
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    cfg_t        debounce_reg, double_gap_reg, long_press_reg;
    logic        held_reg, held_next;
    timer_t      hold_count_reg, hold_count_next;
    logic        await_reg, await_next;
    timer_t      idle_count_reg, idle_count_next;
    logic        long_rep_reg, long_rep_next;
    logic        m_valid_reg, m_valid_next;
    event_kind_t m_kind_reg, m_kind_next;

    logic        accept;
    logic        pressed;
    timer_t      hold_inc;
    timer_t      idle_inc;
    logic        result;
    event_kind_t result_kind;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            double_gap_reg <= DOUBLE_GAP_RESET;
            long_press_reg <= LONG_PRESS_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr == ADDR_DEBOUNCE)
            begin
                debounce_reg <= pwdata[CFG_BITS-1:0];
            end
            if (paddr == ADDR_DOUBLE_GAP)
            begin
                double_gap_reg <= pwdata[CFG_BITS-1:0];
            end
            if (paddr == ADDR_LONG_PRESS)
            begin
                long_press_reg <= pwdata[CFG_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_DEBOUNCE:   prdata = DATA_BITS'(debounce_reg);
            ADDR_DOUBLE_GAP: prdata = DATA_BITS'(double_gap_reg);
            ADDR_LONG_PRESS: prdata = DATA_BITS'(long_press_reg);
            default:         prdata = '0;
        endcase
    end

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign pressed  = !s_tdata[0];
    assign hold_inc = sat_inc(hold_count_reg);
    assign idle_inc = sat_inc(idle_count_reg);

    // press state update and classification of one item
    always_comb
    begin
        held_next       = held_reg;
        hold_count_next = hold_count_reg;
        await_next      = await_reg;
        idle_count_next = idle_count_reg;
        long_rep_next   = long_rep_reg;
        result          = 1'b0;
        result_kind     = EV_SINGLE;

        if (held_reg)
        begin
            hold_count_next = hold_inc;
            if (!pressed)
            begin
                held_next       = 1'b0;
                idle_count_next = '0;
                if (long_rep_reg)
                begin
                    long_rep_next = 1'b0;
                end
                else if (hold_inc < debounce_reg)
                begin
                    result = 1'b0;
                end
                else if (hold_inc >= long_press_reg)
                begin
                    await_next  = 1'b0;
                    result      = 1'b1;
                    result_kind = EV_LONG;
                end
                else if (await_reg)
                begin
                    await_next  = 1'b0;
                    result      = 1'b1;
                    result_kind = EV_DOUBLE;
                end
                else
                begin
                    await_next = 1'b1;
                end
            end
            else if (!long_rep_reg && hold_inc >= long_press_reg)
            begin
                long_rep_next = 1'b1;
                await_next    = 1'b0;
                result        = 1'b1;
                result_kind   = EV_LONG;
            end
        end
        else if (pressed)
        begin
            held_next       = 1'b1;
            hold_count_next = '0;
            long_rep_next   = 1'b0;
            // zero long time reports on the press tick itself
            if (long_press_reg == '0)
            begin
                long_rep_next = 1'b1;
                await_next    = 1'b0;
                result        = 1'b1;
                result_kind   = EV_LONG;
            end
        end
        else if (await_reg)
        begin
            idle_count_next = idle_inc;
            if (idle_inc >= double_gap_reg)
            begin
                await_next  = 1'b0;
                result      = 1'b1;
                result_kind = EV_SINGLE;
            end
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (accept && result)
        begin
            m_valid_next = 1'b1;
            m_kind_next  = result_kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= 1'b0;
            hold_count_reg <= '0;
            await_reg      <= 1'b0;
            idle_count_reg <= '0;
            long_rep_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                held_reg       <= held_next;
                hold_count_reg <= hold_count_next;
                await_reg      <= await_next;
                idle_count_reg <= idle_count_next;
                long_rep_reg   <= long_rep_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_kind_reg <= m_kind_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_kind_reg};

endmodule

// ===== hdl/bpc_checker.sv =====
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level assertions for the button press classifier, bound to the top
// level.
// ----------------------------------------------------------------------------
module bpc_checker
    import bpc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       pready
);

    // only the three defined event codes leave the block
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] != EV_UNUSED && m_tdata[7:2] == 6'd0))
        else $error("illegal event kind");

    // input side never stalls while the output register is empty
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a fresh result item needs an accepted input item in the cycle before
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !$past(m_tvalid && !m_tready)) |-> $past(s_tvalid && s_tready))
        else $error("result item without input item");

    // stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result item changed");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
